// ===== src/gmlp_pkg.sv =====
// Shared types, constants and helper functions of the G-code move line parser.
// Used by the front, the back and the top level; depends on nothing.
package gmlp_pkg;

  localparam int FracDigits = 3;
  localparam int FracW = $clog2(FracDigits + 1);
  localparam int AccW = 32;
  localparam logic [AccW-1:0] SatMag = 32'h8000_0000;
  localparam logic [AccW-1:0] PosMax = 32'h7FFF_FFFF;
  localparam logic [3:0] CountMax = 4'd15;
  localparam int LenW = 9;

  localparam logic [3:0] DigG0 = 4'd0;
  localparam logic [3:0] DigG1 = 4'd1;
  localparam logic [3:0] DigG2 = 4'd2;
  localparam logic [3:0] DigG8 = 4'd8;

  typedef enum logic [2:0] {
    CC_OTHER,
    CC_SPACE,
    CC_G,
    CC_AXIS,
    CC_DIGIT,
    CC_SIGN,
    CC_DOT
  } char_class_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_G,
    PH_G01,
    PH_G2,
    PH_G28,
    PH_NUM_PRE,
    PH_NUM_SIGN,
    PH_NUM_DOT0,
    PH_NUM_INT,
    PH_NUM_FRAC,
    PH_DONE
  } scan_phase_e;

  typedef enum logic [1:0] {
    MC_NONE,
    MC_G0,
    MC_G1,
    MC_G28
  } move_code_e;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef struct packed {
    char_class_e cls;
    logic [3:0]  arg;
  } char_tok_t;

  typedef struct packed {
    logic             valid;
    logic [AccW-1:0]  acc;
    logic             neg;
    logic [FracW-1:0] fd;
    axis_e            axis;
  } commit_t;

  function automatic char_tok_t classify(input logic [7:0] c);
    char_tok_t t;
    t.cls = CC_OTHER;
    t.arg = '0;
    if (c >= "0" && c <= "9") begin
      t.cls = CC_DIGIT;
      t.arg = c[3:0];
    end else begin
      case (c)
        " ", 8'h09: t.cls = CC_SPACE;
        "G", "g": t.cls = CC_G;
        "X", "x": begin
          t.cls = CC_AXIS;
          t.arg = 4'(AXIS_X);
        end
        "Y", "y": begin
          t.cls = CC_AXIS;
          t.arg = 4'(AXIS_Y);
        end
        "Z", "z": begin
          t.cls = CC_AXIS;
          t.arg = 4'(AXIS_Z);
        end
        "-": begin
          t.cls = CC_SIGN;
          t.arg = 4'd1;
        end
        "+": t.cls = CC_SIGN;
        ".": t.cls = CC_DOT;
        default: t.cls = CC_OTHER;
      endcase
    end
    return t;
  endfunction

  function automatic logic [AccW-1:0] add_digit(input logic [AccW-1:0] acc,
                                                input logic [3:0] d);
    logic [AccW+3:0] m;
    m = (36'(acc) << 3) + (36'(acc) << 1) + 36'(d);
    return (m > 36'(SatMag)) ? SatMag : m[AccW-1:0];
  endfunction

  function automatic logic [AccW-1:0] scale_value(input commit_t cm);
    logic [41:0] a;
    logic [41:0] m;
    a = 42'(cm.acc);
    case (cm.fd)
      2'd0: m = (a << 10) - (a << 4) - (a << 3);
      2'd1: m = (a << 6) + (a << 5) + (a << 2);
      2'd2: m = (a << 3) + (a << 1);
      default: m = a;
    endcase
    if (cm.neg) begin
      return (m >= 42'(SatMag)) ? SatMag : AccW'(0 - m[AccW-1:0]);
    end
    return (m > 42'(PosMax)) ? PosMax : m[AccW-1:0];
  endfunction

endpackage

// ===== src/gmlp_char_if.sv =====
// Character channel of the G-code move line parser: valid/ready, one byte and an end-of-line flag.
// Depends on nothing.
interface gmlp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_line;

  modport source (output valid, output char_in, output end_of_line, input ready);
  modport sink (input valid, input char_in, input end_of_line, output ready);
endinterface

// ===== src/gmlp_result_if.sv =====
// Result channel of the G-code move line parser: valid/ready and one line summary.
// Depends on nothing.
interface gmlp_result_if;
  logic               valid;
  logic               ready;
  logic [8:0]         matched_length;
  logic [1:0]         move_code;
  logic [3:0]         g_word_count;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic signed [31:0] z_value;
  logic [2:0]         axes_seen;

  modport source (output valid, output matched_length, output move_code,
                  output g_word_count, output x_value, output y_value,
                  output z_value, output axes_seen, input ready);
  modport sink (input valid, input matched_length, input move_code,
                input g_word_count, input x_value, input y_value,
                input z_value, input axes_seen, output ready);
endinterface

// ===== src/gmlp_fifo.sv =====
// Small register queue between the front and back of the parser.
// Depends on nothing.
module gmlp_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== src/gmlp_front.sv =====
// Front of the parser: takes characters, counts positions and classifies them.
// Depends on gmlp_pkg and gmlp_char_if; feeds the queue.
module gmlp_front #(
  parameter int MaxLineChars = 256,
  parameter int PosW = 9,
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  gmlp_char_if.sink        char_i,
  input  logic             full_i,
  output logic             push_o,
  output logic [Width-1:0] data_o
);

  localparam int TokW = $bits(gmlp_pkg::char_tok_t);

  logic [PosW-1:0]     pos_q, pos_d, end_pos;
  logic                at_limit;
  gmlp_pkg::char_tok_t tok;

  assign char_i.ready = !full_i;
  assign push_o       = char_i.valid && !full_i;
  assign at_limit     = (pos_q >= PosW'(MaxLineChars));
  assign end_pos      = at_limit ? pos_q : pos_q + 1'b1;

  always_comb begin
    tok = gmlp_pkg::classify(char_i.char_in);
    if (at_limit) begin
      tok.cls = gmlp_pkg::CC_OTHER;
      tok.arg = '0;
    end
    pos_d = pos_q;
    if (push_o) begin
      pos_d = char_i.end_of_line ? '0 : end_pos;
    end
  end

  assign data_o = {char_i.end_of_line, end_pos, pos_q, TokW'(tok)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== src/gmlp_back.sv =====
// Back of the parser: scanner state machine, coordinate commit stage and result register.
// Depends on gmlp_pkg and gmlp_result_if; drains the queue.
module gmlp_back #(
  parameter int PosW = 9,
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  logic [Width-1:0] data_i,
  output logic             pop_o,
  gmlp_result_if.source    res_o
);

  localparam int TokW = $bits(gmlp_pkg::char_tok_t);
  localparam int AccW = gmlp_pkg::AccW;
  localparam int LenW = gmlp_pkg::LenW;

  typedef struct packed {
    gmlp_pkg::scan_phase_e     phase;
    logic [AccW-1:0]           acc;
    logic                      neg;
    logic [gmlp_pkg::FracW-1:0] fd;
    gmlp_pkg::axis_e           axis;
    logic [PosW-1:0]           held;
    gmlp_pkg::move_code_e      pend;
    gmlp_pkg::move_code_e      code;
    logic [3:0]                cnt;
    logic [PosW-1:0]           stop;
  } scan_t;

  function automatic scan_t feed(input scan_t s, input gmlp_pkg::char_tok_t t,
                                 input logic [PosW-1:0] pos,
                                 output gmlp_pkg::commit_t cm);
    scan_t n;
    logic  redo;
    logic  add;
    logic  dig;
    n    = s;
    redo = 1'b0;
    add  = 1'b0;
    dig  = (t.cls == gmlp_pkg::CC_DIGIT);
    cm   = gmlp_pkg::commit_t'('0);
    case (s.phase)
      gmlp_pkg::PH_IDLE: redo = 1'b1;
      gmlp_pkg::PH_G: begin
        n.held = pos;
        if (dig && t.arg == gmlp_pkg::DigG0) begin
          n.pend  = gmlp_pkg::MC_G0;
          n.phase = gmlp_pkg::PH_G01;
        end else if (dig && t.arg == gmlp_pkg::DigG1) begin
          n.pend  = gmlp_pkg::MC_G1;
          n.phase = gmlp_pkg::PH_G01;
        end else if (dig && t.arg == gmlp_pkg::DigG2) begin
          n.phase = gmlp_pkg::PH_G2;
        end else begin
          n.phase = gmlp_pkg::PH_IDLE;
          redo    = 1'b1;
        end
      end
      gmlp_pkg::PH_G01, gmlp_pkg::PH_G28: begin
        if (dig) begin
          n.stop  = s.held;
          n.phase = gmlp_pkg::PH_DONE;
        end else begin
          n.code  = (s.phase == gmlp_pkg::PH_G28) ? gmlp_pkg::MC_G28 : s.pend;
          n.cnt   = (s.cnt == gmlp_pkg::CountMax) ? s.cnt : s.cnt + 1'b1;
          n.phase = gmlp_pkg::PH_IDLE;
          redo    = 1'b1;
        end
      end
      gmlp_pkg::PH_G2: begin
        if (dig && t.arg == gmlp_pkg::DigG8) begin
          n.phase = gmlp_pkg::PH_G28;
        end else begin
          n.stop  = s.held;
          n.phase = gmlp_pkg::PH_DONE;
        end
      end
      gmlp_pkg::PH_NUM_PRE: begin
        if (t.cls == gmlp_pkg::CC_SPACE) begin
          n.phase = s.phase;
        end else if (t.cls == gmlp_pkg::CC_SIGN) begin
          n.held  = pos;
          n.neg   = t.arg[0];
          n.phase = gmlp_pkg::PH_NUM_SIGN;
        end else if (t.cls == gmlp_pkg::CC_DOT) begin
          n.held  = pos;
          n.phase = gmlp_pkg::PH_NUM_DOT0;
        end else if (dig) begin
          add     = 1'b1;
          n.phase = gmlp_pkg::PH_NUM_INT;
        end else begin
          n.phase = gmlp_pkg::PH_IDLE;
          redo    = 1'b1;
        end
      end
      gmlp_pkg::PH_NUM_SIGN: begin
        if (dig) begin
          add     = 1'b1;
          n.phase = gmlp_pkg::PH_NUM_INT;
        end else if (t.cls == gmlp_pkg::CC_DOT) begin
          n.phase = gmlp_pkg::PH_NUM_DOT0;
        end else begin
          n.stop  = s.held;
          n.phase = gmlp_pkg::PH_DONE;
        end
      end
      gmlp_pkg::PH_NUM_DOT0, gmlp_pkg::PH_NUM_INT, gmlp_pkg::PH_NUM_FRAC: begin
        if (dig && s.phase == gmlp_pkg::PH_NUM_INT) begin
          add = 1'b1;
        end else if (dig) begin
          n.phase = gmlp_pkg::PH_NUM_FRAC;
          if (s.fd < gmlp_pkg::FracW'(gmlp_pkg::FracDigits)) begin
            add  = 1'b1;
            n.fd = s.fd + 1'b1;
          end
        end else if (s.phase == gmlp_pkg::PH_NUM_DOT0) begin
          n.stop  = s.held;
          n.phase = gmlp_pkg::PH_DONE;
        end else if (s.phase == gmlp_pkg::PH_NUM_INT &&
                     t.cls == gmlp_pkg::CC_DOT) begin
          n.phase = gmlp_pkg::PH_NUM_FRAC;
        end else begin
          cm.valid = 1'b1;
          cm.acc   = s.acc;
          cm.neg   = s.neg;
          cm.fd    = s.fd;
          cm.axis  = s.axis;
          n.phase  = gmlp_pkg::PH_IDLE;
          redo     = 1'b1;
        end
      end
      default: n.phase = s.phase;
    endcase
    if (add) begin
      n.acc = gmlp_pkg::add_digit(s.acc, t.arg);
    end
    if (redo) begin
      case (t.cls)
        gmlp_pkg::CC_SPACE: n.phase = gmlp_pkg::PH_IDLE;
        gmlp_pkg::CC_G: n.phase = gmlp_pkg::PH_G;
        gmlp_pkg::CC_AXIS: begin
          n.axis  = gmlp_pkg::axis_e'(t.arg[1:0]);
          n.acc   = '0;
          n.neg   = 1'b0;
          n.fd    = '0;
          n.phase = gmlp_pkg::PH_NUM_PRE;
        end
        default: begin
          n.stop  = pos;
          n.phase = gmlp_pkg::PH_DONE;
        end
      endcase
    end
    return n;
  endfunction

  gmlp_pkg::char_tok_t tok, end_tok;
  logic [PosW-1:0]     pos, end_pos;
  logic                eol, en, pop;
  scan_t               s_q, s_d, s_a, s_b;
  gmlp_pkg::commit_t   cm_a, cm_b, cm_d;
  logic [PosW+LenW-1:0] stop_ext;

  logic                 p_valid_q, p_eol_q;
  gmlp_pkg::commit_t    p_cm_q;
  logic [LenW-1:0]      p_len_q;
  gmlp_pkg::move_code_e p_code_q;
  logic [3:0]           p_cnt_q;

  logic [AccW-1:0] x_q, y_q, z_q, x_d, y_d, z_d, value;
  logic [2:0]      flags_q, flags_d;
  logic            out_valid_q, load;
  logic [AccW-1:0] ox_q, oy_q, oz_q;
  logic [2:0]      oflags_q;
  logic [LenW-1:0] olen_q;
  logic [1:0]      ocode_q;
  logic [3:0]      ocnt_q;

  assign tok     = gmlp_pkg::char_tok_t'(data_i[TokW-1:0]);
  assign pos     = data_i[TokW +: PosW];
  assign end_pos = data_i[TokW+PosW +: PosW];
  assign eol     = data_i[Width-1];
  assign end_tok = '{cls: gmlp_pkg::CC_OTHER, arg: 4'd0};

  assign en    = !out_valid_q || res_o.ready;
  assign pop   = en && !empty_i;
  assign pop_o = pop;

  always_comb begin
    s_a = feed(s_q, tok, pos, cm_a);
    cm_b = gmlp_pkg::commit_t'('0);
    s_b = s_a;
    if (eol && s_a.phase != gmlp_pkg::PH_DONE) begin
      s_b = feed(s_a, end_tok, end_pos, cm_b);
    end
    cm_d = cm_a.valid ? cm_a : cm_b;
    s_d  = s_q;
    if (pop) begin
      s_d = eol ? scan_t'('0) : s_b;
    end
    stop_ext = (PosW+LenW)'(s_b.stop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q       <= scan_t'('0);
      p_valid_q <= 1'b0;
    end else begin
      s_q <= s_d;
      if (en) begin
        p_valid_q <= pop;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      p_eol_q  <= eol;
      p_cm_q   <= cm_d;
      p_len_q  <= (s_b.cnt == '0) ? '0 : stop_ext[LenW-1:0];
      p_code_q <= s_b.code;
      p_cnt_q  <= s_b.cnt;
    end
  end

  assign value = gmlp_pkg::scale_value(p_cm_q);
  assign load  = en && p_valid_q && p_eol_q;

  always_comb begin
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    flags_d = flags_q;
    if (p_cm_q.valid) begin
      case (p_cm_q.axis)
        gmlp_pkg::AXIS_X: x_d = value;
        gmlp_pkg::AXIS_Y: y_d = value;
        default: z_d = value;
      endcase
      flags_d = flags_q | (3'b001 << p_cm_q.axis);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en && p_valid_q) begin
        if (p_eol_q) begin
          x_q     <= '0;
          y_q     <= '0;
          z_q     <= '0;
          flags_q <= '0;
        end else begin
          x_q     <= x_d;
          y_q     <= y_d;
          z_q     <= z_d;
          flags_q <= flags_d;
        end
      end
      if (en) begin
        out_valid_q <= load;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ox_q     <= x_d;
      oy_q     <= y_d;
      oz_q     <= z_d;
      oflags_q <= flags_d;
      olen_q   <= p_len_q;
      ocode_q  <= 2'(p_code_q);
      ocnt_q   <= p_cnt_q;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.matched_length = olen_q;
  assign res_o.move_code      = ocode_q;
  assign res_o.g_word_count   = ocnt_q;
  assign res_o.x_value        = ox_q;
  assign res_o.y_value        = oy_q;
  assign res_o.z_value        = oz_q;
  assign res_o.axes_seen      = oflags_q;

endmodule

// ===== src/gcode_move_line_parser_top.sv =====
// Top level of the G-code move line parser: front, queue and back joined.
// Depends on gmlp_pkg, gmlp_char_if, gmlp_result_if, gmlp_front, gmlp_fifo and gmlp_back.

// The parser takes one character per cycle while the queue has room and sends one
// summary when the character marked as the end of the line has been scanned. It
// recognizes G0, G1, G28 and X, Y, Z words, with the coordinates returned in signed
// thousandths. A character passes the queue, the scanner stage and the commit stage,
// each a register, before the summary of its line is sent. The scanner takes one
// queued character every cycle, so input runs at a steady one character per cycle
// while the result channel keeps up; a stalled result holds the back, and the queue
// of QueueDepth entries absorbs input until it fills.
module gcode_move_line_parser_top #(
  parameter int MaxLineChars = 256,
  parameter int QueueDepth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gmlp_char_if.sink     char_i,
  gmlp_result_if.source result_o
);

  localparam int PosW = $clog2(MaxLineChars + 1);
  localparam int Width = $bits(gmlp_pkg::char_tok_t) + 2 * PosW + 1;

  logic             push, pop, full, empty;
  logic [Width-1:0] push_data, pop_data;

  gmlp_front #(
    .MaxLineChars(MaxLineChars),
    .PosW(PosW),
    .Width(Width)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .char_i(char_i),
    .full_i(full),
    .push_o(push),
    .data_o(push_data)
  );

  gmlp_fifo #(
    .Width(Width),
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i(push_data),
    .pop_i(pop),
    .data_o(pop_data),
    .full_o(full),
    .empty_o(empty)
  );

  gmlp_back #(
    .PosW(PosW),
    .Width(Width)
  ) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .empty_i(empty),
    .data_i(pop_data),
    .pop_o(pop),
    .res_o(result_o)
  );

  a_len_needs_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.g_word_count == 4'd0 |-> result_o.matched_length == '0)
    else $error("Stop position reported for a line without G words.");

  a_code_matches_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |->
      ((result_o.g_word_count == 4'd0) == (result_o.move_code == 2'(gmlp_pkg::MC_NONE))))
    else $error("Move code and G word count disagree.");

  a_absent_axes_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |->
      (result_o.axes_seen[0] || result_o.x_value == '0) &&
      (result_o.axes_seen[1] || result_o.y_value == '0) &&
      (result_o.axes_seen[2] || result_o.z_value == '0))
    else $error("Coordinate of an absent axis is not zero.");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty |-> !pop)
    else $error("Queue read while empty.");

endmodule
